FILE: hw/rtl/elg_pkg.sv
// Shared types, constants and helper functions for the ECEF to geodetic converter.
// No dependencies; every other design file of the block except elg_checker imports this package.
package elg_pkg;

  localparam int CORDIC_STAGES = 32;
  localparam int ANGLE_BITS    = 32;
  localparam int STG_W         = $clog2(CORDIC_STAGES);
  localparam int AWX           = ANGLE_BITS + 2;   // angle accumulator width
  localparam int W             = 56;               // Q16 length datapath width
  localparam int RW            = 34;               // Q30 sine/cosine width
  localparam int VW            = 50;               // multiplier magnitude operand width
  localparam int CW            = 32;               // multiplier coefficient width
  localparam int MUL_SH        = 30;
  localparam int FRAC_BITS     = 16;
  localparam int LAT           = 4 * CORDIC_STAGES + 11;

  localparam logic [63:0] PI_Q60       = 64'h3243F6A8885A308D;
  localparam logic [CW-1:0] INV_GAIN_Q30 = CW'(652032874);

  localparam logic [29:0] SEMI_MAJOR_RST = 30'd637813700;
  localparam logic [29:0] SEMI_MINOR_RST = 30'd635675231;

  localparam logic signed [AWX-1:0] ANG_QUARTER = AWX'(1) <<< (ANGLE_BITS - 2);

  localparam int DIVN = 60 + FRAC_BITS;            // dividend bits, Q16
  localparam int QW   = 31 + FRAC_BITS + 1;        // kept quotient bits

  typedef enum logic [1:0] {
    REG_SEMI_MAJOR = 2'd0,
    REG_SEMI_MINOR = 2'd1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    CS_SQUARE,
    CS_DIFF,
    CS_DIVIDE,
    CS_IDLE
  } coef_state_e;

  typedef struct packed {
    logic [QW-1:0] c1_mag;   // e^2 * a, Q16 cm
    logic          c1_neg;
    logic [QW-1:0] c2_mag;   // e'^2 * b, Q16 cm
    logic          c2_neg;
  } coef_t;

  typedef struct packed {
    logic                    zero;
    logic signed [AWX-1:0]   lon;
    logic signed [W-1:0]     p;
    logic signed [W-1:0]     av;
    logic signed [31:0]      z;
  } side_t;

  typedef struct packed {
    logic signed [W-1:0]   x;
    logic signed [W-1:0]   y;
    logic signed [AWX-1:0] ang;
    side_t                 side;
  } vec_t;

  typedef struct packed {
    logic signed [RW-1:0]  x;
    logic signed [RW-1:0]  y;
    logic signed [AWX-1:0] w;
    side_t                 side;
  } rot_t;

  typedef logic [CORDIC_STAGES-1:0][ANGLE_BITS-1:0] atan_tab_t;

  // atan(2^-i)/pi * 2^(ANGLE_BITS-1), truncated, from an exact integer series.
  function automatic logic [63:0] atan_entry(int i);
    logic [63:0] pw;
    logic [63:0] sum;
    logic [63:0] term;
    logic [63:0] r;
    logic [63:0] q;
    if (i == 0) begin
      q = 64'd1 << (ANGLE_BITS - 3);
    end else begin
      pw  = (i <= 60) ? (64'd1 << (60 - i)) : 64'd0;
      sum = '0;
      for (int k = 0; k < 64; k++) begin
        if (pw != 0) begin
          term = pw / 64'(2 * k + 1);
          if (k % 2 == 1) sum = sum - term;
          else sum = sum + term;
          pw = (2 * i < 64) ? (pw >> (2 * i)) : 64'd0;
        end
      end
      r = sum;
      q = '0;
      for (int n = 0; n < ANGLE_BITS - 1; n++) begin
        r = r << 1;
        q = q << 1;
        if (r >= PI_Q60) begin
          r = r - PI_Q60;
          q = q | 64'd1;
        end
      end
    end
    return q;
  endfunction

  function automatic atan_tab_t build_atan();
    atan_tab_t t;
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      t[i] = ANGLE_BITS'(atan_entry(i));
    end
    return t;
  endfunction

  localparam atan_tab_t ATAN_ROM = build_atan();

  // Quadrant fold ahead of a vectoring chain; also flags the zero vector.
  function automatic vec_t vec_pre(logic signed [W-1:0] x, logic signed [W-1:0] y,
                                   side_t side);
    vec_t r;
    r           = '0;
    r.side      = side;
    r.side.zero = (x == 0) && (y == 0);
    r.x         = x;
    r.y         = y;
    r.ang       = '0;
    if (x < 0) begin
      if (y >= 0) begin
        r.x   = y;
        r.y   = -x;
        r.ang = ANG_QUARTER;
      end else begin
        r.x   = -y;
        r.y   = x;
        r.ang = -ANG_QUARTER;
      end
    end
    return r;
  endfunction

  localparam int OUT_SH = (ANGLE_BITS >= 32) ? ANGLE_BITS - 32 : 0;
  localparam int OUT_SL = (ANGLE_BITS >= 32) ? 0 : 32 - ANGLE_BITS;

  function automatic logic [31:0] to_out32(logic signed [AWX-1:0] v);
    logic signed [AWX+31:0] t;
    t = (AWX + 32)'(v);
    t = (t >>> OUT_SH) <<< OUT_SL;
    return t[31:0];
  endfunction

endpackage

FILE: hw/rtl/elg_vec_cell.sv
// One vectoring CORDIC micro-rotation, registered.
// Depends on elg_pkg for vec_t and the datapath widths.
module elg_vec_cell import elg_pkg::*; (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic [STG_W-1:0]      stage_i,
  input  logic [ANGLE_BITS-1:0] atan_i,
  input  vec_t                  d_i,
  output vec_t                  q_o
);

  vec_t q_d, q_q;
  logic signed [W-1:0]   xs, ys;
  logic signed [AWX-1:0] step;

  always_comb begin
    xs   = d_i.x >>> stage_i;
    ys   = d_i.y >>> stage_i;
    step = $signed({2'b00, atan_i});
    q_d  = d_i;
    if (d_i.y >= 0) begin
      q_d.x   = d_i.x + ys;
      q_d.y   = d_i.y - xs;
      q_d.ang = d_i.ang + step;
    end else begin
      q_d.x   = d_i.x - ys;
      q_d.y   = d_i.y + xs;
      q_d.ang = d_i.ang - step;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) q_q <= q_d;
  end

  assign q_o = q_q;

endmodule

FILE: hw/rtl/elg_rot_cell.sv
// One rotation CORDIC micro-rotation, registered.
// Depends on elg_pkg for rot_t and the datapath widths.
module elg_rot_cell import elg_pkg::*; (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic [STG_W-1:0]      stage_i,
  input  logic [ANGLE_BITS-1:0] atan_i,
  input  rot_t                  d_i,
  output rot_t                  q_o
);

  rot_t q_d, q_q;
  logic signed [RW-1:0]  xs, ys;
  logic signed [AWX-1:0] step;

  always_comb begin
    xs   = d_i.x >>> stage_i;
    ys   = d_i.y >>> stage_i;
    step = $signed({2'b00, atan_i});
    q_d  = d_i;
    if (d_i.w >= 0) begin
      q_d.x = d_i.x - ys;
      q_d.y = d_i.y + xs;
      q_d.w = d_i.w - step;
    end else begin
      q_d.x = d_i.x + ys;
      q_d.y = d_i.y - xs;
      q_d.w = d_i.w + step;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) q_q <= q_d;
  end

  assign q_o = q_q;

endmodule

FILE: hw/rtl/elg_mul.sv
// Two-stage signed scaling: floor(v * c / 2^30) on magnitudes, sign applied last.
// Depends on elg_pkg; the wide operand is split in two partial products.
module elg_mul import elg_pkg::*; (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic [VW-1:0]       v_i,
  input  logic [CW-1:0]       c_i,
  input  logic                neg_i,
  input  side_t               side_i,
  output logic signed [W-1:0] res_o,
  output side_t               side_o
);

  logic [VW-32+CW-1:0] ph_q;
  logic [63:0]         pl_q;
  logic                neg_q;
  side_t               side1_q, side2_q;
  logic [W-1:0]        sum;
  logic signed [W-1:0] res_d, res_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ph_q    <= (VW - 32 + CW)'(v_i[VW-1:32]) * (VW - 32 + CW)'(c_i);
      pl_q    <= 64'(v_i[31:0]) * 64'(c_i);
      neg_q   <= neg_i;
      side1_q <= side_i;
    end
  end

  always_comb begin
    sum   = (W'(ph_q) << (32 - MUL_SH)) + W'(pl_q[63:MUL_SH]);
    res_d = neg_q ? -$signed(sum) : $signed(sum);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q   <= res_d;
      side2_q <= side1_q;
    end
  end

  assign res_o  = res_q;
  assign side_o = side2_q;

endmodule

FILE: hw/rtl/elg_coef.sv
// Semi-axis registers and the Bowring coefficients e^2*a and e'^2*b.
// Depends on elg_pkg; two restoring dividers run side by side, one bit a cycle.
module elg_coef import elg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [29:0] cfg_data_i,
  output coef_t       coef_o,
  output logic [29:0] a_o,
  output logic [29:0] b_o,
  output logic        busy_o
);

  coef_state_e state_q, state_d;
  logic [29:0]      a_q, b_q;
  logic [59:0]      aa_q, bb_q;
  logic             dneg_q;
  logic [DIVN-1:0]  num_q;
  logic [6:0]       cnt_q;
  logic [29:0]      rem_q [2];
  logic [QW-1:0]    quo_q [2];
  logic             ovf_q [2];
  logic [29:0]      den   [2];
  logic [30:0]      part  [2];
  logic             ge    [2];
  logic [QW-1:0]    mag   [2];
  logic [60:0]      diff;
  logic [59:0]      dmag;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q <= SEMI_MAJOR_RST;
      b_q <= SEMI_MINOR_RST;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_SEMI_MAJOR: a_q <= cfg_data_i;
        REG_SEMI_MINOR: b_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      CS_SQUARE: state_d = CS_DIFF;
      CS_DIFF:   state_d = CS_DIVIDE;
      CS_DIVIDE: if (cnt_q == 7'(DIVN - 1)) state_d = CS_IDLE;
      CS_IDLE:   state_d = CS_IDLE;
      default:   state_d = CS_SQUARE;
    endcase
    if (cfg_valid_i) state_d = CS_SQUARE;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= CS_SQUARE;
    else state_q <= state_d;
  end

  always_comb begin
    den[0]  = a_q;
    den[1]  = b_q;
    diff    = {1'b0, aa_q} - {1'b0, bb_q};
    dmag    = diff[60] ? 60'(-diff) : diff[59:0];
    for (int l = 0; l < 2; l++) begin
      part[l] = {rem_q[l], num_q[DIVN-1]};
      ge[l]   = part[l] >= {1'b0, den[l]};
      if (den[l] == '0) mag[l] = '0;
      else if (ovf_q[l] || quo_q[l][QW-1]) mag[l] = QW'(1) << (QW - 1);
      else mag[l] = quo_q[l];
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      CS_SQUARE: begin
        aa_q <= 60'(a_q) * 60'(a_q);
        bb_q <= 60'(b_q) * 60'(b_q);
      end
      CS_DIFF: begin
        dneg_q <= diff[60];
        num_q  <= {dmag, FRAC_BITS'(0)};
        cnt_q  <= '0;
        for (int l = 0; l < 2; l++) begin
          rem_q[l] <= '0;
          quo_q[l] <= '0;
          ovf_q[l] <= 1'b0;
        end
      end
      CS_DIVIDE: begin
        num_q <= num_q << 1;
        cnt_q <= cnt_q + 7'd1;
        for (int l = 0; l < 2; l++) begin
          rem_q[l] <= ge[l] ? 30'(part[l] - {1'b0, den[l]}) : part[l][29:0];
          quo_q[l] <= {quo_q[l][QW-2:0], ge[l]};
          ovf_q[l] <= ovf_q[l] | quo_q[l][QW-1];
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    busy_o        = (state_q != CS_IDLE);
    a_o           = a_q;
    b_o           = b_q;
    coef_o.c1_mag = mag[0];
    coef_o.c1_neg = dneg_q;
    coef_o.c2_mag = mag[1];
    coef_o.c2_neg = dneg_q;
  end

endmodule

FILE: hw/rtl/ecef_to_geodetic_latlon.sv
// Top level: ECEF point to geodetic longitude and latitude (Bowring's method).
// Depends on elg_pkg, elg_vec_cell, elg_rot_cell, elg_mul and elg_coef.
//
//   channel   direction  payload (low bits first)                handshake
//   s_axis    in         ecef_x[31:0] ecef_y[63:32] ecef_z[95:64] tvalid/tready
//   m_axis    out        longitude[31:0] latitude[63:32]          tvalid/tready
//   cfg       in         index, 30-bit semi-axis value            valid/ready
//
// One item enters per cycle while s_axis_tready_o is high, and each result
// passes through the four CORDIC chains on its way out.
// After reset and after every configuration write the coefficient dividers
// run, and s_axis_tready_o stays low until they finish.
// A stall on m_axis freezes the whole pipeline, and s_axis_tready_o falls in
// the same cycle; the configuration channel is always ready.
module ecef_to_geodetic_latlon import elg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [95:0] s_axis_tdata_i,   // ecef_x, ecef_y, ecef_z
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o,   // longitude, latitude
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [29:0] cfg_data_i
);

  logic        adv, in_acc, busy;
  logic [LAT-1:0] vld_q;
  coef_t       coef;
  logic [29:0] axis_a, axis_b;

  // Input registers.
  logic signed [31:0] x_q, y_q, z_q;

  vec_t a_chain [CORDIC_STAGES+1];
  vec_t b_chain [CORDIC_STAGES+1];
  vec_t l_chain [CORDIC_STAGES+1];
  rot_t r_chain [CORDIC_STAGES+1];

  side_t a_side, mp_side, mbv_in_side, mbv_side, mnum_side, corr_side, sum_side_q;
  logic signed [W-1:0] mp_res, mav_res, mbv_res, mnum_res, mden_res;
  logic [31:0] z_mag;

  // Cube stages.
  side_t       c1_side_q, c2_side_q;
  logic [31:0] mc_d, ms_d, mc_q, ms_q, m2c_q, m2s_q, c3m_q, s3m_q;
  logic        cneg1_q, sneg1_q, cneg2_q, sneg2_q;

  logic signed [W-1:0] num_q, den_q;

  logic signed [AWX-1:0] lat_raw;
  logic [31:0] lon_q, lat_q;

  // The whole pipeline moves unless a finished result waits on a stalled sink.
  assign adv             = !vld_q[LAT-1] || m_axis_tready_i;
  assign s_axis_tready_o = adv && !busy;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_ready_o     = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[LAT-2:0], in_acc};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      x_q <= s_axis_tdata_i[31:0];
      y_q <= s_axis_tdata_i[63:32];
      z_q <= s_axis_tdata_i[95:64];
    end
  end

  elg_coef u_coef (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_index_i,
    .cfg_data_i,
    .coef_o (coef),
    .a_o    (axis_a),
    .b_o    (axis_b),
    .busy_o (busy)
  );

  // Longitude: vectoring chain on (x, y) in Q16 centimetres.
  always_comb begin
    a_side      = '0;
    a_side.z    = z_q;
    a_chain[0]  = vec_pre({{(W-48){x_q[31]}}, x_q, 16'b0},
                          {{(W-48){y_q[31]}}, y_q, 16'b0}, a_side);
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_lon
    elg_vec_cell u_cell (
      .clk_i,
      .en_i    (adv),
      .stage_i (STG_W'(i)),
      .atan_i  (ATAN_ROM[i]),
      .d_i     (a_chain[i]),
      .q_o     (a_chain[i+1])
    );
  end

  // The chain magnitude carries the CORDIC gain; scaling by its inverse gives p.
  // a*z is formed alongside it.
  always_comb begin
    mp_side     = a_chain[CORDIC_STAGES].side;
    mp_side.lon = a_chain[CORDIC_STAGES].side.zero ? '0 : a_chain[CORDIC_STAGES].ang;
    z_mag       = a_chain[CORDIC_STAGES].side.z[31] ? 32'(-a_chain[CORDIC_STAGES].side.z)
                                                    : a_chain[CORDIC_STAGES].side.z;
  end

  elg_mul u_mul_p (
    .clk_i,
    .en_i   (adv),
    .v_i    (a_chain[CORDIC_STAGES].x[VW-1:0]),
    .c_i    (INV_GAIN_Q30),
    .neg_i  (1'b0),
    .side_i (mp_side),
    .res_o  (mp_res),
    .side_o (mbv_side)
  );

  elg_mul u_mul_av (
    .clk_i,
    .en_i   (adv),
    .v_i    ({(VW-48)'(0), z_mag, 16'b0}),
    .c_i    (CW'(axis_a)),
    .neg_i  (a_chain[CORDIC_STAGES].side.z[31]),
    .side_i (mp_side),
    .res_o  (mav_res),
    .side_o ()
  );

  // b*p, with p and a*z kept alongside for the later stages.
  always_comb begin
    mbv_in_side    = mbv_side;
    mbv_in_side.p  = mp_res;
    mbv_in_side.av = mav_res;
  end

  elg_mul u_mul_bv (
    .clk_i,
    .en_i   (adv),
    .v_i    (mp_res[VW-1:0]),
    .c_i    (CW'(axis_b)),
    .neg_i  (1'b0),
    .side_i (mbv_in_side),
    .res_o  (mbv_res),
    .side_o (mnum_side)
  );

  // Parametric angle: vectoring chain on (b*p, a*z).
  assign b_chain[0] = vec_pre(mbv_res, mnum_side.av, mnum_side);

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_par
    elg_vec_cell u_cell (
      .clk_i,
      .en_i    (adv),
      .stage_i (STG_W'(i)),
      .atan_i  (ATAN_ROM[i]),
      .d_i     (b_chain[i]),
      .q_o     (b_chain[i+1])
    );
  end

  // Cosine and sine of the parametric angle, Q30.
  always_comb begin
    r_chain[0].x    = RW'(INV_GAIN_Q30);
    r_chain[0].y    = '0;
    r_chain[0].w    = b_chain[CORDIC_STAGES].side.zero ? '0 : b_chain[CORDIC_STAGES].ang;
    r_chain[0].side = b_chain[CORDIC_STAGES].side;
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_rot
    elg_rot_cell u_cell (
      .clk_i,
      .en_i    (adv),
      .stage_i (STG_W'(i)),
      .atan_i  (ATAN_ROM[i]),
      .d_i     (r_chain[i]),
      .q_o     (r_chain[i+1])
    );
  end

  // Cubes on magnitudes, one multiplication per stage; signs ride alongside.
  always_comb begin
    mc_d = r_chain[CORDIC_STAGES].x[RW-1] ? 32'(-r_chain[CORDIC_STAGES].x)
                                          : 32'(r_chain[CORDIC_STAGES].x);
    ms_d = r_chain[CORDIC_STAGES].y[RW-1] ? 32'(-r_chain[CORDIC_STAGES].y)
                                          : 32'(r_chain[CORDIC_STAGES].y);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mc_q      <= mc_d;
      ms_q      <= ms_d;
      m2c_q     <= 32'((64'(mc_d) * 64'(mc_d)) >> 30);
      m2s_q     <= 32'((64'(ms_d) * 64'(ms_d)) >> 30);
      cneg1_q   <= r_chain[CORDIC_STAGES].x[RW-1];
      sneg1_q   <= r_chain[CORDIC_STAGES].y[RW-1];
      c1_side_q <= r_chain[CORDIC_STAGES].side;
      c3m_q     <= 32'((64'(m2c_q) * 64'(mc_q)) >> 30);
      s3m_q     <= 32'((64'(m2s_q) * 64'(ms_q)) >> 30);
      cneg2_q   <= cneg1_q;
      sneg2_q   <= sneg1_q;
      c2_side_q <= c1_side_q;
    end
  end

  // Correction terms e'^2*b*sin^3 and e^2*a*cos^3.
  elg_mul u_mul_num (
    .clk_i,
    .en_i   (adv),
    .v_i    (VW'(coef.c2_mag)),
    .c_i    (s3m_q),
    .neg_i  (coef.c2_neg ^ sneg2_q),
    .side_i (c2_side_q),
    .res_o  (mnum_res),
    .side_o (corr_side)
  );

  elg_mul u_mul_den (
    .clk_i,
    .en_i   (adv),
    .v_i    (VW'(coef.c1_mag)),
    .c_i    (c3m_q),
    .neg_i  (coef.c1_neg ^ cneg2_q),
    .side_i (c2_side_q),
    .res_o  (mden_res),
    .side_o ()
  );

  always_ff @(posedge clk_i) begin
    if (adv) begin
      num_q      <= {{(W-48){corr_side.z[31]}}, corr_side.z, 16'b0} + mnum_res;
      den_q      <= corr_side.p - mden_res;
      sum_side_q <= corr_side;
    end
  end

  // Latitude: vectoring chain on (p - e^2*a*cos^3, z + e'^2*b*sin^3).
  assign l_chain[0] = vec_pre(den_q, num_q, sum_side_q);

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_lat
    elg_vec_cell u_cell (
      .clk_i,
      .en_i    (adv),
      .stage_i (STG_W'(i)),
      .atan_i  (ATAN_ROM[i]),
      .d_i     (l_chain[i]),
      .q_o     (l_chain[i+1])
    );
  end

  // Points deep inside the ellipsoid can overshoot a pole; clamp to +-pi/2.
  always_comb begin
    lat_raw = l_chain[CORDIC_STAGES].side.zero ? '0 : l_chain[CORDIC_STAGES].ang;
    if (lat_raw > ANG_QUARTER) lat_raw = ANG_QUARTER;
    if (lat_raw < -ANG_QUARTER) lat_raw = -ANG_QUARTER;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      lon_q <= to_out32(l_chain[CORDIC_STAGES].side.lon);
      lat_q <= to_out32(lat_raw);
    end
  end

  assign m_axis_tvalid_o = vld_q[LAT-1];
  assign m_axis_tdata_o  = {lat_q, lon_q};

endmodule

FILE: hw/rtl/elg_checker.sv
// Port-level checks for the ECEF to geodetic converter, bound to the top level.
// Depends only on the top level's ports.
module elg_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [63:0] m_axis_tdata_o,
  input logic        cfg_valid_i,
  input logic        cfg_ready_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result item dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o))
    else $error("result item changed while stalled");

  a_no_accept_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |-> !s_axis_tready_o)
    else $error("input taken while the pipeline is frozen");

  a_busy_after_cfg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_o |=> !s_axis_tready_o)
    else $error("input taken while coefficients are recomputed");

  a_lat_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> ($signed(m_axis_tdata_o[63:32]) <= 32'sd1073741824) &&
                        ($signed(m_axis_tdata_o[63:32]) >= -32'sd1073741824))
    else $error("latitude outside +-pi/2");

endmodule

bind ecef_to_geodetic_latlon elg_checker u_elg_checker (.*);
